[hw/rtl/acire_pkg.sv]
// ----------------------------------------------------------------------------
// acire_pkg
// Shared types and constants for the air-conditioner IR frame encoder.
// ----------------------------------------------------------------------------
package acire_pkg;

  localparam int DUR_W   = 15;
  localparam int LIM_W   = 17;
  localparam int IDX_W   = 3;
  localparam int FOOT_W  = 3;
  localparam int CNT_W   = 6;
  localparam int SYM_CNT = 70;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_HDR_MARK  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_HDR_SPACE = 3'd1;
  localparam logic [IDX_W-1:0] CFG_DATA_MARK = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SPACE_HI  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_SPACE_LO  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_GAP       = 3'd5;
  localparam logic [IDX_W-1:0] CFG_FOOTER    = 3'd6;

  localparam logic [DUR_W-1:0]  RST_HDR_MARK  = 15'd9000;
  localparam logic [DUR_W-1:0]  RST_HDR_SPACE = 15'd4500;
  localparam logic [DUR_W-1:0]  RST_DATA_MARK = 15'd620;
  localparam logic [DUR_W-1:0]  RST_SPACE_HI  = 15'd1600;
  localparam logic [DUR_W-1:0]  RST_SPACE_LO  = 15'd540;
  localparam logic [DUR_W-1:0]  RST_GAP       = 15'd19980;
  localparam logic [FOOT_W-1:0] RST_FOOTER    = 3'd2;

  // modes and fan codes
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_DRY  = 3'd2;
  localparam logic [2:0] MODE_MAX  = 3'd4;
  localparam logic [1:0] FAN_LOW   = 2'd1;

  localparam logic [7:0] TEMP_MIN  = 8'd16;
  localparam logic [7:0] TEMP_MAX  = 8'd30;
  localparam logic [7:0] TEMP_AUTO = 8'd25;

  // template bytes
  localparam logic [7:0] BYTE1_TPL = 8'h09 & 8'hF0;
  localparam logic [7:0] BYTE2     = 8'h20;
  localparam logic [7:0] BYTE3     = 8'h50;
  localparam logic [7:0] BYTE4     = 8'h00;
  localparam logic [7:0] BYTE5     = 8'h20;
  localparam logic [7:0] BYTE6     = 8'h00;
  localparam logic [3:0] NIB_MASK  = 4'h0F;
  localparam logic [3:0] CSUM_SEED = 4'd10;

  // pair positions
  localparam logic [CNT_W-1:0] PAIR_FIRST = 6'd0;
  localparam logic [CNT_W-1:0] PAIR_GAP   = 6'd18;
  localparam logic [CNT_W-1:0] PAIR_LAST  = 6'd34;

  typedef struct packed {
    logic load;
    logic emit;
    logic hdr;
    logic gap_first;
    logic gap_second;
    logic last;
  } cmd_t;

  function automatic logic [DUR_W-1:0] dur_sat(input logic [DUR_W-1:0] d,
                                               input logic [LIM_W-1:0] lim);
    if ({2'b00, d} > lim) begin
      return lim[DUR_W-1:0];
    end
    return d;
  endfunction

endpackage

[hw/rtl/ac_ir_frame_encoder.sv]
// ----------------------------------------------------------------------------
// ac_ir_frame_encoder
// Air-conditioner IR frame encoder: one setting in, 35 beats of two mark/space pairs out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one setting: mode, fan_speed,
// power_on, temp_set. The block builds the 8-byte frame with its checksum
// and returns 35 output beats of two symbols each: header, first 32 bits,
// footer bits, gap, second 32 bits, final gap. last_pair marks the 35th.
// Configuration channel (cfg_valid/cfg_ready) writes the timing registers
// and the footer code by cfg_index; cfg_ready is always high. Write only
// while no frame is in flight.
// Timing: an accepted setting moves the sequencer into its run state, and
// the first pair is then loaded into the output register; the rest follow
// one per cycle while the output is not stalled. A new setting is taken
// only once the 35th pair has been loaded into the output register.
// A stall on the output holds the current beat and pauses the sequence.
// Reset returns the sequencer to idle, drops out_valid and loads the
// default timings.
// ----------------------------------------------------------------------------
module ac_ir_frame_encoder #(
  parameter int DURATION_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [acire_pkg::IDX_W-1:0]  cfg_index,
  input  logic [acire_pkg::DUR_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   mode,
  input  logic [1:0]                   fan_speed,
  input  logic                         power_on,
  input  logic [7:0]                   temp_set,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [acire_pkg::DUR_W-1:0]  mark_first,
  output logic [acire_pkg::DUR_W-1:0]  space_first,
  output logic [acire_pkg::DUR_W-1:0]  mark_second,
  output logic [acire_pkg::DUR_W-1:0]  space_second,
  output logic                         last_pair
);

  acire_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  acire_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  acire_dp #(
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .mode         (mode),
    .fan_speed    (fan_speed),
    .power_on     (power_on),
    .temp_set     (temp_set),
    .mark_first   (mark_first),
    .space_first  (space_first),
    .mark_second  (mark_second),
    .space_second (space_second),
    .last_pair    (last_pair)
  );

endmodule

[hw/rtl/acire_ctrl.sv]
// ----------------------------------------------------------------------------
// acire_ctrl
// Sequencer: takes a setting, then steps through the 35 symbol pairs.
// ----------------------------------------------------------------------------
module acire_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output acire_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state;
  logic                        state_next;
  logic [acire_pkg::CNT_W-1:0] cnt;
  logic [acire_pkg::CNT_W-1:0] cnt_next;
  logic                        out_valid_next;
  logic                        accept;
  logic                        emit;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign emit     = (state == ST_RUN) & (~out_valid | ~out_stall);

  always_comb begin
    cmd.load       = accept;
    cmd.emit       = emit;
    cmd.hdr        = (cnt == acire_pkg::PAIR_FIRST);
    cmd.gap_first  = (cnt == acire_pkg::PAIR_GAP);
    cmd.gap_second = (cnt == acire_pkg::PAIR_LAST);
    cmd.last       = (cnt == acire_pkg::PAIR_LAST);
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          cnt_next   = acire_pkg::PAIR_FIRST;
        end
      end
      ST_RUN: begin
        if (emit) begin
          out_valid_next = 1'b1;
          if (cnt == acire_pkg::PAIR_LAST) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= acire_pkg::PAIR_FIRST;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hw/rtl/acire_dp.sv]
// ----------------------------------------------------------------------------
// acire_dp
// Timing registers, frame assembly, symbol shift register and output beat.
// ----------------------------------------------------------------------------
module acire_dp #(
  parameter int DURATION_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr,
  input  logic [acire_pkg::IDX_W-1:0]   cfg_index,
  input  logic [acire_pkg::DUR_W-1:0]   cfg_data,
  input  acire_pkg::cmd_t               cmd,
  input  logic [2:0]                    mode,
  input  logic [1:0]                    fan_speed,
  input  logic                          power_on,
  input  logic [7:0]                    temp_set,
  output logic [acire_pkg::DUR_W-1:0]   mark_first,
  output logic [acire_pkg::DUR_W-1:0]   space_first,
  output logic [acire_pkg::DUR_W-1:0]   mark_second,
  output logic [acire_pkg::DUR_W-1:0]   space_second,
  output logic                          last_pair
);

  localparam logic [acire_pkg::LIM_W-1:0] DurLim =
    acire_pkg::LIM_W'((1 << DURATION_BITS) - 1);

  logic [acire_pkg::DUR_W-1:0]  hdr_mark;
  logic [acire_pkg::DUR_W-1:0]  hdr_space;
  logic [acire_pkg::DUR_W-1:0]  data_mark;
  logic [acire_pkg::DUR_W-1:0]  space_hi;
  logic [acire_pkg::DUR_W-1:0]  space_lo;
  logic [acire_pkg::DUR_W-1:0]  gap;
  logic [acire_pkg::FOOT_W-1:0] footer;
  logic [acire_pkg::DUR_W-1:0]  wr_sat;

  logic [acire_pkg::SYM_CNT-1:0] syms;
  logic [2:0]  mcode;
  logic [1:0]  fan;
  logic [7:0]  treq;
  logic [7:0]  tclamp;
  logic [7:0]  toff;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte7;
  logic [3:0]  csum;
  logic [31:0] blk1;
  logic [31:0] blk2;

  assign wr_sat = acire_pkg::dur_sat(cfg_data, DurLim);

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_mark  <= acire_pkg::dur_sat(acire_pkg::RST_HDR_MARK, DurLim);
      hdr_space <= acire_pkg::dur_sat(acire_pkg::RST_HDR_SPACE, DurLim);
      data_mark <= acire_pkg::dur_sat(acire_pkg::RST_DATA_MARK, DurLim);
      space_hi  <= acire_pkg::dur_sat(acire_pkg::RST_SPACE_HI, DurLim);
      space_lo  <= acire_pkg::dur_sat(acire_pkg::RST_SPACE_LO, DurLim);
      gap       <= acire_pkg::dur_sat(acire_pkg::RST_GAP, DurLim);
      footer    <= acire_pkg::RST_FOOTER;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        acire_pkg::CFG_HDR_MARK:  hdr_mark  <= wr_sat;
        acire_pkg::CFG_HDR_SPACE: hdr_space <= wr_sat;
        acire_pkg::CFG_DATA_MARK: data_mark <= wr_sat;
        acire_pkg::CFG_SPACE_HI:  space_hi  <= wr_sat;
        acire_pkg::CFG_SPACE_LO:  space_lo  <= wr_sat;
        acire_pkg::CFG_GAP:       gap       <= wr_sat;
        acire_pkg::CFG_FOOTER:    footer    <= cfg_data[acire_pkg::FOOT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame assembly
  always_comb begin
    mcode = (mode <= acire_pkg::MODE_MAX) ? mode : acire_pkg::MODE_AUTO;
    fan   = (mode == acire_pkg::MODE_DRY) ? acire_pkg::FAN_LOW : fan_speed;
    treq  = (mode == acire_pkg::MODE_AUTO) ? acire_pkg::TEMP_AUTO : temp_set;
    if (treq < acire_pkg::TEMP_MIN) begin
      tclamp = acire_pkg::TEMP_MIN;
    end else if (treq > acire_pkg::TEMP_MAX) begin
      tclamp = acire_pkg::TEMP_MAX;
    end else begin
      tclamp = treq;
    end
    toff  = tclamp - acire_pkg::TEMP_MIN;
    byte0 = {2'b00, fan, power_on, mcode};
    byte1 = (acire_pkg::BYTE1_TPL & 8'hF0) | {4'h0, toff[3:0]};
    csum  = acire_pkg::CSUM_SEED + byte0[3:0] + byte1[3:0]
          + (acire_pkg::BYTE2[3:0] & acire_pkg::NIB_MASK)
          + (acire_pkg::BYTE3[3:0] & acire_pkg::NIB_MASK)
          + acire_pkg::BYTE4[7:4] + acire_pkg::BYTE5[7:4] + acire_pkg::BYTE6[7:4];
    byte7 = {csum, 4'h0};
    blk1  = {acire_pkg::BYTE3, acire_pkg::BYTE2, byte1, byte0};
    blk2  = {byte7, acire_pkg::BYTE6, acire_pkg::BYTE5, acire_pkg::BYTE4};
  end

  // symbol data bits, lowest first; header and gap slots carry zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      syms <= {1'b0, blk2, 1'b0, footer, blk1, 1'b0};
    end else if (cmd.emit) begin
      syms <= {2'b00, syms[acire_pkg::SYM_CNT-1:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mark_first  <= cmd.hdr ? hdr_mark : data_mark;
      if (cmd.hdr) begin
        space_first <= hdr_space;
      end else if (cmd.gap_first) begin
        space_first <= gap;
      end else begin
        space_first <= syms[0] ? space_hi : space_lo;
      end
      mark_second <= data_mark;
      if (cmd.gap_second) begin
        space_second <= gap;
      end else begin
        space_second <= syms[1] ? space_hi : space_lo;
      end
      last_pair <= cmd.last;
    end
  end

endmodule
